@@ sv/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

@@ sv/dthk_pkg.sv @@
// ----------------------------------------------------------------------------
// dthk_pkg
// Types, constants and knob tables of the dual thermostat.
// ----------------------------------------------------------------------------
package dthk_pkg;

  localparam int ADC_W    = 10;
  localparam int BAND_W   = 8;
  localparam int HOT_SP_W = 7;
  localparam int CLD_SP_W = 5;
  localparam int TEMP_W   = 10;

  localparam int HOT_KNOB_POINTS  = 5;
  localparam int COLD_KNOB_POINTS = 6;

  localparam logic [ADC_W-1:0] HOT_KNOB_ADC [HOT_KNOB_POINTS] =
    '{10'd0, 10'd450, 10'd611, 10'd743, 10'd765};
  localparam logic [HOT_SP_W-1:0] HOT_KNOB_DEG [HOT_KNOB_POINTS] =
    '{7'd70, 7'd75, 7'd80, 7'd85, 7'd90};
  localparam logic [ADC_W-1:0] COLD_KNOB_ADC [COLD_KNOB_POINTS] =
    '{10'd0, 10'd300, 10'd550, 10'd662, 10'd745, 10'd755};
  localparam logic [CLD_SP_W-1:0] COLD_KNOB_DEG [COLD_KNOB_POINTS] =
    '{5'd7, 5'd9, 5'd11, 5'd13, 5'd15, 5'd17};

  localparam logic [ADC_W:0]      KNOB_OVERRANGE = 11'd20;
  localparam logic [HOT_SP_W-1:0] HOT_DEFAULT    = 7'd80;
  localparam logic [CLD_SP_W-1:0] COLD_DEFAULT   = 5'd13;
  localparam logic [ADC_W-1:0]    MISSING_LIMIT  = 10'd10;

  localparam logic [TEMP_W-1:0] HOT_OVER   = 10'd960;
  localparam logic [TEMP_W-1:0] HOT_UNDER  = 10'd640;
  localparam logic [TEMP_W-1:0] HOT_BASE   = 10'd650;
  localparam logic [TEMP_W-1:0] COLD_OVER  = 10'd330;
  localparam logic [TEMP_W-1:0] COLD_UNDER = 10'd10;
  localparam logic [TEMP_W-1:0] COLD_BASE  = 10'd25;

  // linear span of both sensors in tenths of a degree
  localparam int LIN_SPAN   = 300;
  localparam int SPAN_W     = 9;
  localparam int DIV_NUM_W  = ADC_W + SPAN_W;
  localparam int QUOT_W     = 9;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    REG_HOT_CAL_LOW,
    REG_HOT_CAL_HIGH,
    REG_COLD_CAL_LOW,
    REG_COLD_CAL_HIGH,
    REG_HOT_BAND,
    REG_COLD_BAND,
    REG_HOLD_TICKS,
    REG_SETTLE_TICKS
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KNOB,
    S_LOAD,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  // nearest breakpoint, ties go up, small overrange holds the last step
  function automatic logic [HOT_SP_W-1:0] hot_knob_map(input logic [ADC_W-1:0] v);
    logic [HOT_SP_W-1:0] cand;
    logic [ADC_W:0]      last;
    cand = HOT_DEFAULT;
    last = {1'b0, HOT_KNOB_ADC[HOT_KNOB_POINTS-1]};
    if (v < HOT_KNOB_ADC[0]) begin
      cand = HOT_DEFAULT;
    end else if ({1'b0, v} > last) begin
      cand = ({1'b0, v} <= last + KNOB_OVERRANGE) ?
             HOT_KNOB_DEG[HOT_KNOB_POINTS-1] : HOT_DEFAULT;
    end else begin
      for (int j = 0; j < HOT_KNOB_POINTS - 1; j++) begin
        if (v >= HOT_KNOB_ADC[j] && v <= HOT_KNOB_ADC[j+1]) begin
          cand = ({1'b0, v} << 1) < ({1'b0, HOT_KNOB_ADC[j]} + {1'b0, HOT_KNOB_ADC[j+1]}) ?
                 HOT_KNOB_DEG[j] : HOT_KNOB_DEG[j+1];
        end
      end
    end
    return cand;
  endfunction

  function automatic logic [CLD_SP_W-1:0] cold_knob_map(input logic [ADC_W-1:0] v);
    logic [CLD_SP_W-1:0] cand;
    logic [ADC_W:0]      last;
    cand = COLD_DEFAULT;
    last = {1'b0, COLD_KNOB_ADC[COLD_KNOB_POINTS-1]};
    if (v < COLD_KNOB_ADC[0]) begin
      cand = COLD_DEFAULT;
    end else if ({1'b0, v} > last) begin
      cand = ({1'b0, v} <= last + KNOB_OVERRANGE) ?
             COLD_KNOB_DEG[COLD_KNOB_POINTS-1] : COLD_DEFAULT;
    end else begin
      for (int j = 0; j < COLD_KNOB_POINTS - 1; j++) begin
        if (v >= COLD_KNOB_ADC[j] && v <= COLD_KNOB_ADC[j+1]) begin
          cand = ({1'b0, v} << 1) <
                 ({1'b0, COLD_KNOB_ADC[j]} + {1'b0, COLD_KNOB_ADC[j+1]}) ?
                 COLD_KNOB_DEG[j] : COLD_KNOB_DEG[j+1];
        end
      end
    end
    return cand;
  endfunction

endpackage

@@ sv/dthk_div.sv @@
// ----------------------------------------------------------------------------
// dthk_div
// Restoring divider, one quotient bit per cycle, for quotients below 2^QUOT_W.
// ----------------------------------------------------------------------------
module dthk_div
  import dthk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [ADC_W-1:0]     den,
  output div_rsp_t             rsp
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [ADC_W-1:0]     rem;
  logic [QUOT_W-1:0]    nsh;
  logic [QUOT_W-1:0]    quot;
  logic                 done;
  logic [ADC_W:0]       trial;
  logic                 fits;

  // upper numerator bits already sit below den since the quotient is bounded
  assign trial = {rem, nsh[QUOT_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num[DIV_NUM_W-1:QUOT_W];
      nsh  <= num[QUOT_W-1:0];
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? ADC_W'(trial - {1'b0, den}) : trial[ADC_W-1:0];
      nsh  <= {nsh[QUOT_W-2:0], 1'b0};
      quot <= {quot[QUOT_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

@@ sv/dual_thermostat_with_knob_setpoint.sv @@
// ----------------------------------------------------------------------------
// dual_thermostat_with_knob_setpoint
// Two bang-bang relays with hysteresis, knob setpoints and calibrated sensors.
// ----------------------------------------------------------------------------
// One input word holds four ADC samples and yields one result word. The next word
// is accepted only after the previous one is finished. Each word passes through
// the shared restoring divider, which scales the hot and then the cold sensor in
// two passes of 9 steps each. A finished result waits in the output register while
// the next word is taken; a result not yet taken holds the following one in its
// last step. Configuration writes are always accepted and belong in idle periods.
`include "assert_macros.svh"

module dual_thermostat_with_knob_setpoint
  import dthk_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ADC_W-1:0]    hot_sense,
  input  logic [ADC_W-1:0]    cold_sense,
  input  logic [ADC_W-1:0]    hot_knob,
  input  logic [ADC_W-1:0]    cold_knob,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                heater_on,
  output logic                cooler_on,
  output logic [TEMP_W-1:0]   hot_temp,
  output logic [TEMP_W-1:0]   cold_temp,
  output logic [HOT_SP_W-1:0] hot_setpoint_out,
  output logic [CLD_SP_W-1:0] cold_setpoint_out,
  output logic                temp_changed,
  output logic                setpoint_changed,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [ADC_W-1:0]    cfg_data
);

  // configuration
  logic [ADC_W-1:0]  hot_cal_low, hot_cal_high, cold_cal_low, cold_cal_high;
  logic [BAND_W-1:0] hot_band, cold_band, hold_ticks, settle_ticks;

  // sampled input word
  logic [ADC_W-1:0] hs, cs, hk, ck;

  // thermostat state
  state_t              state, state_next;
  logic [HOT_SP_W-1:0] hot_setpoint, hot_setpoint_next, hot_pending, hot_pending_next;
  logic [CLD_SP_W-1:0] cold_setpoint, cold_setpoint_next, cold_pending, cold_pending_next;
  logic [BAND_W-1:0]   hot_settle_count, hot_settle_count_next;
  logic [BAND_W-1:0]   cold_settle_count, cold_settle_count_next;
  logic [TEMP_W-1:0]   hot_temp_reg, cold_temp_reg;
  logic [BAND_W-1:0]   heater_hold_count, heater_hold_count_next;
  logic [BAND_W-1:0]   cooler_hold_count, cooler_hold_count_next;
  logic                heater_relay, heater_relay_next, cooler_relay, cooler_relay_next;
  logic                sp_chg, sp_chg_next;
  logic                ch, ch_next;
  logic [QUOT_W-1:0]   lin_hot, lin_cold;

  // divider interface
  logic                 div_start;
  logic [ADC_W-1:0]     diff, den;
  logic [DIV_NUM_W-1:0] num;
  div_rsp_t             div_rsp;
  logic [QUOT_W-1:0]    lin_q;

  // knob candidates and settle terms
  logic [HOT_SP_W-1:0] hc, hsp0, hpd0;
  logic [CLD_SP_W-1:0] cc, csp0, cpd0;
  logic [BAND_W-1:0]   hcnt_inc, ccnt_inc;

  // final temperatures and relay bounds
  logic [TEMP_W-1:0]   ht, ct;
  logic [TEMP_W-1:0]   hot_sp10, cold_sp10;
  logic signed [11:0]  h_t, h_lo, h_hi, c_t, c_lo, c_hi;
  logic [BAND_W-1:0]   hh_inc, ch_inc;
  logic                fin_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      hot_cal_low   <= 10'd374;
      hot_cal_high  <= 10'd537;
      cold_cal_low  <= 10'd443;
      cold_cal_high <= 10'd770;
      hot_band      <= 8'd50;
      cold_band     <= 8'd25;
      hold_ticks    <= 8'd30;
      settle_ticks  <= 8'd10;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HOT_CAL_LOW:   hot_cal_low   <= cfg_data;
        REG_HOT_CAL_HIGH:  hot_cal_high  <= cfg_data;
        REG_COLD_CAL_LOW:  cold_cal_low  <= cfg_data;
        REG_COLD_CAL_HIGH: cold_cal_high <= cfg_data;
        REG_HOT_BAND:      hot_band      <= cfg_data[BAND_W-1:0];
        REG_COLD_BAND:     cold_band     <= cfg_data[BAND_W-1:0];
        REG_HOLD_TICKS:    hold_ticks    <= cfg_data[BAND_W-1:0];
        REG_SETTLE_TICKS:  settle_ticks  <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hs <= hot_sense;
      cs <= cold_sense;
      hk <= hot_knob;
      ck <= cold_knob;
    end
  end

  // shared scaling unit: (s - low) * 300 / (high - low)
  assign diff = ch ? (cs - cold_cal_low) : (hs - hot_cal_low);
  assign den  = ch ? (cold_cal_high - cold_cal_low) : (hot_cal_high - hot_cal_low);
  assign num  = DIV_NUM_W'(diff) * DIV_NUM_W'(LIN_SPAN);

  dthk_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .rsp   (div_rsp)
  );

  // equal or inverted calibration points leave only the base
  assign lin_q = ch ? ((cold_cal_high <= cold_cal_low) ? '0 : div_rsp.quot)
                    : ((hot_cal_high <= hot_cal_low) ? '0 : div_rsp.quot);

  always_ff @(posedge clk) begin
    if (state == S_DIV && div_rsp.done) begin
      if (ch) lin_cold <= lin_q;
      else    lin_hot  <= lin_q;
    end
  end

  // temperatures from the sampled sensors
  always_comb begin
    if (hs > hot_cal_high || hs <= MISSING_LIMIT) begin
      ht = HOT_OVER;
    end else if (hs < hot_cal_low) begin
      ht = HOT_UNDER;
    end else begin
      ht = HOT_BASE + TEMP_W'(lin_hot);
    end
    if (cs > cold_cal_high) begin
      ct = COLD_OVER;
    end else if (cs < cold_cal_low) begin
      ct = COLD_UNDER;
    end else begin
      ct = COLD_BASE + TEMP_W'(lin_cold);
    end
  end

  assign hot_sp10  = TEMP_W'(hot_setpoint) * TEMP_W'(10);
  assign cold_sp10 = TEMP_W'(cold_setpoint) * TEMP_W'(10);
  assign h_t  = $signed({2'b00, ht});
  assign h_lo = $signed({2'b00, hot_sp10}) - $signed({4'b0000, hot_band});
  assign h_hi = $signed({2'b00, hot_sp10}) + $signed({4'b0000, hot_band});
  assign c_t  = $signed({2'b00, ct});
  assign c_lo = $signed({2'b00, cold_sp10}) - $signed({4'b0000, cold_band});
  assign c_hi = $signed({2'b00, cold_sp10}) + $signed({4'b0000, cold_band});
  assign hh_inc = heater_hold_count + 1'b1;
  assign ch_inc = cooler_hold_count + 1'b1;

  assign hc       = hot_knob_map(hk);
  assign cc       = cold_knob_map(ck);
  assign hsp0     = (hot_setpoint == '0) ? hc : hot_setpoint;
  assign csp0     = (hot_setpoint == '0) ? cc : cold_setpoint;
  assign hpd0     = (hot_setpoint == '0) ? hc : hot_pending;
  assign cpd0     = (hot_setpoint == '0) ? cc : cold_pending;
  assign hcnt_inc = hot_settle_count + 1'b1;
  assign ccnt_inc = cold_settle_count + 1'b1;

  always_comb begin
    state_next             = state;
    hot_setpoint_next      = hot_setpoint;
    cold_setpoint_next     = cold_setpoint;
    hot_pending_next       = hot_pending;
    cold_pending_next      = cold_pending;
    hot_settle_count_next  = hot_settle_count;
    cold_settle_count_next = cold_settle_count;
    heater_hold_count_next = heater_hold_count;
    cooler_hold_count_next = cooler_hold_count;
    heater_relay_next      = heater_relay;
    cooler_relay_next      = cooler_relay;
    sp_chg_next            = sp_chg;
    ch_next                = ch;
    div_start              = 1'b0;
    fin_load               = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_KNOB;
      end
      S_KNOB: begin
        sp_chg_next        = (hot_setpoint == '0);
        hot_setpoint_next  = hsp0;
        cold_setpoint_next = csp0;
        hot_pending_next   = hpd0;
        cold_pending_next  = cpd0;
        if (hpd0 == hc) begin
          hot_settle_count_next = hcnt_inc;
          if (hcnt_inc > settle_ticks) begin
            hot_settle_count_next = '0;
            if (hsp0 != hpd0) begin
              hot_setpoint_next = hpd0;
              sp_chg_next       = 1'b1;
            end
          end
        end else begin
          hot_settle_count_next = '0;
          hot_pending_next      = hc;
        end
        if (cpd0 == cc) begin
          cold_settle_count_next = ccnt_inc;
          if (ccnt_inc > settle_ticks) begin
            cold_settle_count_next = '0;
            if (csp0 != cpd0) begin
              cold_setpoint_next = cpd0;
              sp_chg_next        = 1'b1;
            end
          end
        end else begin
          cold_settle_count_next = '0;
          cold_pending_next      = cc;
        end
        ch_next    = 1'b0;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (ch) begin
            state_next = S_FIN;
          end else begin
            ch_next    = 1'b1;
            state_next = S_LOAD;
          end
        end
      end
      S_FIN: begin
        // wait for the output register to drain
        if (!out_valid) begin
          fin_load = 1'b1;
          if (h_t < h_lo || h_t > h_hi) begin
            heater_hold_count_next = hh_inc;
            if (hh_inc == hold_ticks) begin
              heater_relay_next      = (h_t < h_lo);
              heater_hold_count_next = '0;
            end
          end else begin
            heater_hold_count_next = '0;
          end
          if (c_t < c_lo || c_t > c_hi) begin
            cooler_hold_count_next = ch_inc;
            if (ch_inc == hold_ticks) begin
              cooler_relay_next      = !(c_t < c_lo);
              cooler_hold_count_next = '0;
            end
          end else begin
            cooler_hold_count_next = '0;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      hot_setpoint      <= '0;
      cold_setpoint     <= '0;
      hot_pending       <= '0;
      cold_pending      <= '0;
      hot_settle_count  <= '0;
      cold_settle_count <= '0;
      hot_temp_reg      <= '0;
      cold_temp_reg     <= '0;
      heater_hold_count <= '0;
      cooler_hold_count <= '0;
      heater_relay      <= 1'b0;
      cooler_relay      <= 1'b0;
      sp_chg            <= 1'b0;
      ch                <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state             <= state_next;
      hot_setpoint      <= hot_setpoint_next;
      cold_setpoint     <= cold_setpoint_next;
      hot_pending       <= hot_pending_next;
      cold_pending      <= cold_pending_next;
      hot_settle_count  <= hot_settle_count_next;
      cold_settle_count <= cold_settle_count_next;
      heater_hold_count <= heater_hold_count_next;
      cooler_hold_count <= cooler_hold_count_next;
      heater_relay      <= heater_relay_next;
      cooler_relay      <= cooler_relay_next;
      sp_chg            <= sp_chg_next;
      ch                <= ch_next;
      if (fin_load) begin
        hot_temp_reg  <= ht;
        cold_temp_reg <= ct;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (fin_load) begin
      heater_on         <= heater_relay_next;
      cooler_on         <= cooler_relay_next;
      hot_temp          <= ht;
      cold_temp         <= ct;
      hot_setpoint_out  <= hot_setpoint;
      cold_setpoint_out <= cold_setpoint;
      temp_changed      <= (ht != hot_temp_reg) || (ct != cold_temp_reg);
      setpoint_changed  <= sp_chg;
    end
  end

  `ASSERT_NEXT(a_relay_only_at_fin, clk, rst, state != S_FIN,
               $stable(heater_relay) && $stable(cooler_relay))
  `ASSERT_IMPLIES(a_div_done_in_div, clk, rst, div_rsp.done, state == S_DIV)
  `ASSERT_IMPLIES(a_setpoint_set, clk, rst, out_valid,
                  hot_setpoint != '0 && cold_setpoint != '0)
  `ASSERT_IMPLIES(a_temp_range, clk, rst, out_valid,
                  hot_temp >= HOT_UNDER && cold_temp <= COLD_OVER)

endmodule

@@ bench/tb_dual_thermostat_with_knob_setpoint.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_thermostat_with_knob_setpoint
// Self-checking bench for the dual thermostat. A scoreboard class carries its
// own model of knob settling, sensor scaling and relay hysteresis, predicts
// one report per accepted sample word and compares each report word field by
// field. Stimulus is a directed opening followed by random runs of steady
// knobs and slowly wandering sensors under several register settings, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_dual_thermostat_with_knob_setpoint
  import dthk_pkg::*;
();

  localparam int HOT_CH         = 0;
  localparam int COLD_CH        = 1;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 30;
  localparam int PHASE_ITEMS    = 96;

  typedef struct packed {
    logic [ADC_W-1:0] hot_sense;
    logic [ADC_W-1:0] cold_sense;
    logic [ADC_W-1:0] hot_knob;
    logic [ADC_W-1:0] cold_knob;
  } tick_t;

  typedef struct packed {
    logic                heater_on;
    logic                cooler_on;
    logic [TEMP_W-1:0]   hot_temp;
    logic [TEMP_W-1:0]   cold_temp;
    logic [HOT_SP_W-1:0] hot_setpoint;
    logic [CLD_SP_W-1:0] cold_setpoint;
    logic                temp_changed;
    logic                setpoint_changed;
  } report_t;

  typedef struct packed {
    logic [ADC_W-1:0]  hot_cal_low;
    logic [ADC_W-1:0]  hot_cal_high;
    logic [ADC_W-1:0]  cold_cal_low;
    logic [ADC_W-1:0]  cold_cal_high;
    logic [BAND_W-1:0] hot_band;
    logic [BAND_W-1:0] cold_band;
    logic [7:0]        hold_ticks;
    logic [7:0]        settle_ticks;
  } setting_t;

  class thermostat_scoreboard;
    int cal_low[2], cal_high[2], band[2];
    int hold_ticks, settle_ticks;
    int setpoint[2], pending[2], settle_cnt[2], hold_cnt[2], temp_reg[2];
    bit relay[2];
    int knob_adc[2][16], knob_deg[2][16], knob_n[2];
    report_t expected_reports[$];
    int errors;

    function new();
      cal_low[HOT_CH]   = 374;
      cal_high[HOT_CH]  = 537;
      cal_low[COLD_CH]  = 443;
      cal_high[COLD_CH] = 770;
      band[HOT_CH]      = 50;
      band[COLD_CH]     = 25;
      hold_ticks        = 30;
      settle_ticks      = 10;
      for (int ch = 0; ch < 2; ch++) begin
        setpoint[ch]   = 0;
        pending[ch]    = 0;
        settle_cnt[ch] = 0;
        hold_cnt[ch]   = 0;
        temp_reg[ch]   = 0;
        relay[ch]      = 1'b0;
      end
      knob_n[HOT_CH]  = HOT_KNOB_POINTS;
      knob_n[COLD_CH] = COLD_KNOB_POINTS;
      for (int j = 0; j < HOT_KNOB_POINTS; j++) begin
        knob_adc[HOT_CH][j] = HOT_KNOB_ADC[j];
        knob_deg[HOT_CH][j] = HOT_KNOB_DEG[j];
      end
      for (int j = 0; j < COLD_KNOB_POINTS; j++) begin
        knob_adc[COLD_CH][j] = COLD_KNOB_ADC[j];
        knob_deg[COLD_CH][j] = COLD_KNOB_DEG[j];
      end
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [ADC_W-1:0] value);
      case (idx)
        REG_HOT_CAL_LOW:   cal_low[HOT_CH]   = value;
        REG_HOT_CAL_HIGH:  cal_high[HOT_CH]  = value;
        REG_COLD_CAL_LOW:  cal_low[COLD_CH]  = value;
        REG_COLD_CAL_HIGH: cal_high[COLD_CH] = value;
        REG_HOT_BAND:      band[HOT_CH]      = value[7:0];
        REG_COLD_BAND:     band[COLD_CH]     = value[7:0];
        REG_HOLD_TICKS:    hold_ticks        = value[7:0];
        REG_SETTLE_TICKS:  settle_ticks      = value[7:0];
        default: ;
      endcase
    endfunction

    // nearest breakpoint, upper one on a tie, short overrange keeps the top step
    function int knob_degree(int ch, int v);
      int n, last, dflt, cand, lo, hi;
      n    = knob_n[ch];
      last = knob_adc[ch][n-1];
      dflt = (ch == HOT_CH) ? int'(HOT_DEFAULT) : int'(COLD_DEFAULT);
      if (v < knob_adc[ch][0]) return dflt;
      if (v > last) return (v <= last + int'(KNOB_OVERRANGE)) ? knob_deg[ch][n-1] : dflt;
      cand = dflt;
      for (int j = 0; j < n - 1; j++) begin
        lo = knob_adc[ch][j];
        hi = knob_adc[ch][j+1];
        if (v >= lo && v <= hi) cand = ((v - lo) < (hi - v)) ? knob_deg[ch][j] : knob_deg[ch][j+1];
      end
      return cand;
    endfunction

    function bit settle_knob(int ch, int cand);
      bit changed;
      changed = 1'b0;
      if (pending[ch] == cand) begin
        settle_cnt[ch] = (settle_cnt[ch] + 1) & 255;
        if (settle_cnt[ch] > settle_ticks) begin
          settle_cnt[ch] = 0;
          if (setpoint[ch] != pending[ch]) begin
            setpoint[ch] = pending[ch];
            changed = 1'b1;
          end
        end
      end else begin
        settle_cnt[ch] = 0;
        pending[ch] = cand;
      end
      return changed;
    endfunction

    function int scaled(int ch, int s);
      if (cal_high[ch] <= cal_low[ch]) return 0;
      return (s - cal_low[ch]) * LIN_SPAN / (cal_high[ch] - cal_low[ch]);
    endfunction

    function void relay_update(int ch, int t, bit on_low);
      int lo, hi;
      lo = setpoint[ch] * 10 - band[ch];
      hi = setpoint[ch] * 10 + band[ch];
      if (t < lo || t > hi) begin
        hold_cnt[ch] = (hold_cnt[ch] + 1) & 255;
        if (hold_cnt[ch] == hold_ticks) begin
          relay[ch] = ((t < lo) == on_low);
          hold_cnt[ch] = 0;
        end
      end else begin
        hold_cnt[ch] = 0;
      end
    endfunction

    function void note_tick(tick_t t);
      int cand[2], temp[2];
      int hs, cs;
      bit sp_changed, t_changed;
      report_t r;
      cand[HOT_CH]  = knob_degree(HOT_CH, t.hot_knob);
      cand[COLD_CH] = knob_degree(COLD_CH, t.cold_knob);
      sp_changed = 1'b0;
      // no hot setpoint yet: take both candidates straight away
      if (setpoint[HOT_CH] == 0) begin
        for (int ch = 0; ch < 2; ch++) begin
          setpoint[ch] = cand[ch];
          pending[ch]  = cand[ch];
        end
        sp_changed = 1'b1;
      end
      for (int ch = 0; ch < 2; ch++) begin
        if (settle_knob(ch, cand[ch])) sp_changed = 1'b1;
      end

      hs = t.hot_sense;
      cs = t.cold_sense;
      // a near-zero hot sample means the sensor is gone
      if (hs > cal_high[HOT_CH] || hs <= MISSING_LIMIT) temp[HOT_CH] = HOT_OVER;
      else if (hs < cal_low[HOT_CH]) temp[HOT_CH] = HOT_UNDER;
      else temp[HOT_CH] = HOT_BASE + scaled(HOT_CH, hs);
      if (cs > cal_high[COLD_CH]) temp[COLD_CH] = COLD_OVER;
      else if (cs < cal_low[COLD_CH]) temp[COLD_CH] = COLD_UNDER;
      else temp[COLD_CH] = COLD_BASE + scaled(COLD_CH, cs);

      t_changed = (temp[HOT_CH] != temp_reg[HOT_CH]) || (temp[COLD_CH] != temp_reg[COLD_CH]);
      temp_reg[HOT_CH]  = temp[HOT_CH];
      temp_reg[COLD_CH] = temp[COLD_CH];

      relay_update(HOT_CH, temp[HOT_CH], 1'b1);
      relay_update(COLD_CH, temp[COLD_CH], 1'b0);

      r.heater_on        = relay[HOT_CH];
      r.cooler_on        = relay[COLD_CH];
      r.hot_temp         = TEMP_W'(temp[HOT_CH]);
      r.cold_temp        = TEMP_W'(temp[COLD_CH]);
      r.hot_setpoint     = HOT_SP_W'(setpoint[HOT_CH]);
      r.cold_setpoint    = CLD_SP_W'(setpoint[COLD_CH]);
      r.temp_changed     = t_changed;
      r.setpoint_changed = sp_changed;
      expected_reports.push_back(r);
    endfunction

    function void check_field(string what, int want, int got);
      if (want != got) begin
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t report word with nothing expected: actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      check_field("heater_on", want.heater_on, got.heater_on);
      check_field("cooler_on", want.cooler_on, got.cooler_on);
      check_field("hot_temp", want.hot_temp, got.hot_temp);
      check_field("cold_temp", want.cold_temp, got.cold_temp);
      check_field("hot_setpoint_out", want.hot_setpoint, got.hot_setpoint);
      check_field("cold_setpoint_out", want.cold_setpoint, got.cold_setpoint);
      check_field("temp_changed", want.temp_changed, got.temp_changed);
      check_field("setpoint_changed", want.setpoint_changed, got.setpoint_changed);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ADC_W-1:0]    hot_sense = '0;
  logic [ADC_W-1:0]    cold_sense = '0;
  logic [ADC_W-1:0]    hot_knob = '0;
  logic [ADC_W-1:0]    cold_knob = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                heater_on;
  logic                cooler_on;
  logic [TEMP_W-1:0]   hot_temp;
  logic [TEMP_W-1:0]   cold_temp;
  logic [HOT_SP_W-1:0] hot_setpoint_out;
  logic [CLD_SP_W-1:0] cold_setpoint_out;
  logic                temp_changed;
  logic                setpoint_changed;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  reg_idx_t            cfg_index = REG_HOT_CAL_LOW;
  logic [ADC_W-1:0]    cfg_data = '0;

  thermostat_scoreboard sb;
  logic    no_idle = 1'b0;
  bit      held_once = 1'b0;
  int      stall_left = 0;
  int      quiet_cycles = 0;
  report_t seen_report;
  tick_t   seen_tick;

  dual_thermostat_with_knob_setpoint dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .hot_sense         (hot_sense),
    .cold_sense        (cold_sense),
    .hot_knob          (hot_knob),
    .cold_knob         (cold_knob),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .heater_on         (heater_on),
    .cooler_on         (cooler_on),
    .hot_temp          (hot_temp),
    .cold_temp         (cold_temp),
    .hot_setpoint_out  (hot_setpoint_out),
    .cold_setpoint_out (cold_setpoint_out),
    .temp_changed      (temp_changed),
    .setpoint_changed  (setpoint_changed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // report side: short random stalls, now and then a long one
  always @(posedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      stall_left <= $urandom_range(1, 40);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      // the report leaving now is always older than a word taken now
      if (out_valid && out_ready) begin
        seen_report = {heater_on, cooler_on, hot_temp, cold_temp, hot_setpoint_out,
                       cold_setpoint_out, temp_changed, setpoint_changed};
        sb.check_report(seen_report);
      end
      if (in_valid && in_ready) begin
        seen_tick = {hot_sense, cold_sense, hot_knob, cold_knob};
        sb.note_tick(seen_tick);
      end
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** dual_thermostat_with_knob_setpoint: FAILED **");
        $finish;
      end
    end
  end

  function automatic tick_t tick_of(int hs, int cs, int hk, int ck);
    tick_t t;
    t.hot_sense  = ADC_W'(hs);
    t.cold_sense = ADC_W'(cs);
    t.hot_knob   = ADC_W'(hk);
    t.cold_knob  = ADC_W'(ck);
    return t;
  endfunction

  function automatic setting_t make_setting(int hcl, int hch, int ccl, int cch,
                                            int hb, int cb, int hold, int settle);
    setting_t s;
    s.hot_cal_low   = ADC_W'(hcl);
    s.hot_cal_high  = ADC_W'(hch);
    s.cold_cal_low  = ADC_W'(ccl);
    s.cold_cal_high = ADC_W'(cch);
    s.hot_band      = BAND_W'(hb);
    s.cold_band     = BAND_W'(cb);
    s.hold_ticks    = 8'(hold);
    s.settle_ticks  = 8'(settle);
    return s;
  endfunction

  function automatic setting_t random_setting();
    int hlo, clo;
    hlo = $urandom_range(0, 900);
    clo = $urandom_range(0, 900);
    return make_setting(hlo, $urandom_range(hlo + 1, 1023), clo, $urandom_range(clo + 1, 1023),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(1, 12), $urandom_range(0, 8));
  endfunction

  function automatic int wander(int base);
    int v;
    v = base + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  task automatic send_tick(tick_t t);
    in_valid   <= 1'b1;
    hot_sense  <= t.hot_sense;
    cold_sense <= t.cold_sense;
    hot_knob   <= t.hot_knob;
    cold_knob  <= t.cold_knob;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer_tick(tick_t t);
    send_tick(t);
    if (!no_idle && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  // hold off the sample side until every report word is back
  task automatic wait_for_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_reports.size() != 0);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [ADC_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(setting_t s);
    write_reg(REG_HOT_CAL_LOW, s.hot_cal_low);
    write_reg(REG_HOT_CAL_HIGH, s.hot_cal_high);
    write_reg(REG_COLD_CAL_LOW, s.cold_cal_low);
    write_reg(REG_COLD_CAL_HIGH, s.cold_cal_high);
    write_reg(REG_HOT_BAND, s.hot_band);
    write_reg(REG_COLD_BAND, s.cold_band);
    write_reg(REG_HOLD_TICKS, s.hold_ticks);
    write_reg(REG_SETTLE_TICKS, s.settle_ticks);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    tick_t opening[8];
    tick_t repeated[8];
    // reset registers: first tick, sensor clamps, missing sensor, knob edges
    opening[0] = tick_of(455, 600, 600, 400);
    opening[1] = tick_of(0, 0, 0, 0);
    opening[2] = tick_of(10, 442, 1023, 1023);
    opening[3] = tick_of(11, 443, 765, 755);
    opening[4] = tick_of(373, 770, 785, 775);
    opening[5] = tick_of(374, 771, 786, 776);
    opening[6] = tick_of(537, 1023, 225, 150);
    opening[7] = tick_of(1023, 500, 224, 149);
    // equal calibration, no band, instant hold and settle; each word twice
    repeated[0] = tick_of(500, 600, 530, 606);
    repeated[1] = tick_of(499, 599, 677, 703);
    repeated[2] = tick_of(501, 601, 754, 704);
    repeated[3] = tick_of(5, 1023, 450, 750);
    repeated[4] = tick_of(900, 100, 611, 300);
    repeated[5] = tick_of(600, 700, 0, 662);
    repeated[6] = tick_of(520, 650, 785, 776);
    repeated[7] = tick_of(700, 610, 786, 745);
    for (int i = 0; i < 8; i++) offer_tick(opening[i]);
    wait_for_reports();
    apply_setting(make_setting(500, 500, 600, 600, 0, 0, 1, 0));
    for (int i = 0; i < 8; i++) begin
      offer_tick(repeated[i]);
      offer_tick(repeated[i]);
    end
  endtask

  // runs of steady knobs and slowly moving sensors, with some noise words
  task automatic run_phase(setting_t s, int count);
    int done_items, run_len, hs_base, cs_base, hk_base, ck_base;
    tick_t t;
    wait_for_reports();
    apply_setting(s);
    done_items = 0;
    while (done_items < count) begin
      run_len = $urandom_range(1, 60);
      hs_base = ($urandom_range(0, 9) < 6) ?
                $urandom_range(s.hot_cal_low, s.hot_cal_high) : $urandom_range(0, 1023);
      cs_base = ($urandom_range(0, 9) < 6) ?
                $urandom_range(s.cold_cal_low, s.cold_cal_high) : $urandom_range(0, 1023);
      hk_base = $urandom_range(0, 1023);
      ck_base = $urandom_range(0, 1023);
      for (int k = 0; k < run_len && done_items < count; k++) begin
        if ($urandom_range(0, 99) < 15) begin
          t = tick_of($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 1023));
        end else begin
          t = tick_of(wander(hs_base), wander(cs_base), hk_base, ck_base);
        end
        offer_tick(t);
        done_items++;
        if ((!held_once && done_items == count / 2) || $urandom_range(0, 99) < 2) begin
          held_once = 1'b1;
          wait_for_reports();
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    run_phase(make_setting(374, 537, 443, 770, 50, 25, 4, 2), PHASE_ITEMS);
    run_phase(make_setting(0, 1023, 0, 1023, 255, 255, 1, 0), PHASE_ITEMS);
    no_idle <= 1'b1;
    run_phase(make_setting(11, 200, 0, 1, 0, 0, 3, 1), PHASE_ITEMS);
    no_idle <= 1'b0;
    run_phase(make_setting(0, 1, 1022, 1023, 0, 0, 255, 254), PHASE_ITEMS);
    run_phase(random_setting(), PHASE_ITEMS);
    run_phase(random_setting(), PHASE_ITEMS);

    wait_for_reports();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("** dual_thermostat_with_knob_setpoint: PASSED **");
    end else begin
      $display("** dual_thermostat_with_knob_setpoint: FAILED **");
    end
    $finish;
  end

endmodule
